// File: rtl/core/frame_bitmap_allocator_unit_defines.svh
// Assertion macros shared by the frame bitmap allocator checker.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FBA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame allocator check failed");

// Next-cycle implication, sampled on clk, off during reset
`define FBA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame allocator check failed");

`endif

// File: rtl/core/fba_pkg.sv
// Shared types and constants for the frame bitmap allocator.
// No dependencies.
package fba_pkg;

	localparam int WORD_W     = 32;
	localparam int BIT_IDX_W  = 5;
	localparam int FRAME_W    = 12;
	localparam int CFG_W      = 13;
	localparam int STATUS_W   = 3;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 13'd4096;

	// request opcodes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// response status codes
	localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_MAPPED    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FREED     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NONE      = 3'd4;

	typedef struct packed {
		logic               cmd;
		logic [FRAME_W-1:0] page_frame;
		logic               kernel_mode;
		logic               writable;
	} fba_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FRAME_W-1:0]  frame_out;
		logic                present_out;
		logic                rw_out;
		logic                user_out;
	} fba_rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_ALLOC_WR,
		S_FREE_WR
	} fba_state_t;

	// bitmap RAM port control
	typedef struct packed {
		logic en;
		logic we;
	} fba_ram_ctl_t;

endpackage

// File: rtl/core/fba_bitmap_ram.sv
// Single-port bitmap RAM, one 32-bit used mask per word, registered read.
// Depends on fba_pkg.
module fba_bitmap_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic                       clk,
	input  fba_pkg::fba_ram_ctl_t      ctl,
	input  logic [AW-1:0]              addr,
	input  logic [fba_pkg::WORD_W-1:0] wdata,
	output logic [fba_pkg::WORD_W-1:0] rdata
);
	import fba_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	// write or read, one access per cycle
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			if (ctl.we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: rtl/core/fba_first_zero.sv
// Lowest-clear-bit finder for one bitmap word.
// Depends on fba_pkg.
module fba_first_zero (
	input  logic [fba_pkg::WORD_W-1:0]    word,
	output logic                          all_ones,
	output logic [fba_pkg::WORD_W-1:0]    onehot,
	output logic [fba_pkg::BIT_IDX_W-1:0] idx
);
	import fba_pkg::*;

	logic [WORD_W-1:0] inv;

	// isolate lowest set bit of the inverted word
	assign inv      = ~word;
	assign onehot   = inv & (~inv + WORD_W'(1));
	assign all_ones = &word;

	// encode the one-hot position
	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (onehot[i]) begin
				idx = idx | BIT_IDX_W'(i);
			end
		end
	end

endmodule

// File: rtl/core/frame_bitmap_allocator_unit.sv
// First-fit page frame allocator, top level: sequencer, config register, result register.
// Depends on fba_pkg, fba_bitmap_ram, fba_first_zero.
//
// After reset the block sweeps the bitmap RAM to zero, one word a cycle,
// with busy high. A request is taken when start is high and busy low.
// Allocate with a nonzero frame, free of frame 0, and free of a frame past
// the bitmap answer in the next cycle and leave busy low. Free of a nonzero
// frame inside the bitmap is a read-modify-write of one RAM word, read on
// the request and written back in S_FREE_WR. Allocate with frame 0 scans
// the words below frame_count/32 (clamped to the bitmap size) through the
// single RAM port at one word a cycle; a word with a clear bit is updated
// in S_ALLOC_WR, and when nothing is free done reports STAT_FULL. The result
// is shown for exactly one cycle with done high; there is no back-pressure,
// so the receiver must capture it then. cfg_ready is always high; write
// frame_count only while no request is outstanding.
module frame_bitmap_allocator_unit #(
	parameter int NUM_FRAMES = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  fba_pkg::fba_req_t         req,
	output logic                      done,
	output fba_pkg::fba_rsp_t         rsp,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [fba_pkg::CFG_W-1:0] cfg_data
);
	import fba_pkg::*;

	localparam int BM_WORDS = NUM_FRAMES / 32;
	localparam int AW       = (BM_WORDS > 1) ? $clog2(BM_WORDS) : 1;
	localparam int CW       = $clog2(BM_WORDS + 1);
	localparam int LW       = (CW > 8) ? CW : 8;
	localparam int XW       = (AW + 1 > 7) ? AW + 1 : 7;

	fba_state_t state_q, state_d;
	fba_req_t   req_q;
	fba_rsp_t   rsp_q, rsp_d;
	logic       done_q, emit;

	logic [CFG_W-1:0] frame_count_q;
	logic [LW-1:0]    cnt_q, cnt_d, fc_words, lim_words;
	logic             chk_valid_q, chk_valid_d;
	logic [AW-1:0]    chk_addr_q;

	fba_ram_ctl_t        ram_ctl;
	logic [AW-1:0]       ram_addr;
	logic [WORD_W-1:0]   ram_wdata, ram_rdata;

	logic                 zero_all_ones;
	logic [WORD_W-1:0]    zero_onehot;
	logic [BIT_IDX_W-1:0] zero_idx;

	logic              accept, scan_found, scan_issue, clr_last;
	logic [XW-1:0]     in_word, q_word;
	logic              in_range;
	logic [WORD_W-1:0] free_mask;

	// bitmap storage and the shared word test unit
	fba_bitmap_ram #(
		.DEPTH(BM_WORDS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.ctl  (ram_ctl),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	fba_first_zero u_first_zero (
		.word    (ram_rdata),
		.all_ones(zero_all_ones),
		.onehot  (zero_onehot),
		.idx     (zero_idx)
	);

	// handshake and scan decode
	assign accept     = start && !busy;
	assign busy       = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign rsp        = rsp_q;

	assign fc_words   = LW'(frame_count_q[CFG_W-1:BIT_IDX_W]);
	assign lim_words  = (fc_words > LW'(BM_WORDS)) ? LW'(BM_WORDS) : fc_words;
	assign scan_found = chk_valid_q && !zero_all_ones;
	assign scan_issue = !scan_found && (cnt_q < lim_words);
	assign clr_last   = (cnt_q == LW'(BM_WORDS - 1));

	assign in_word    = XW'(req.page_frame[FRAME_W-1:BIT_IDX_W]);
	assign q_word     = XW'(req_q.page_frame[FRAME_W-1:BIT_IDX_W]);
	assign in_range   = (in_word < XW'(BM_WORDS));
	assign free_mask  = WORD_W'(1) << req_q.page_frame[BIT_IDX_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_ALLOC && req.page_frame == '0) begin
						state_d = S_SCAN;
					end else if (req.cmd == CMD_FREE && req.page_frame != '0 && in_range) begin
						state_d = S_FREE_WR;
					end
				end
			end
			S_SCAN: begin
				if (scan_found) begin
					state_d = S_ALLOC_WR;
				end else if (!scan_issue) begin
					state_d = S_IDLE;
				end
			end
			S_ALLOC_WR: state_d = S_IDLE;
			S_FREE_WR:  state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// datapath control and response build
	always_comb begin
		ram_ctl     = '0;
		ram_addr    = '0;
		ram_wdata   = '0;
		cnt_d       = cnt_q;
		chk_valid_d = 1'b0;
		emit        = 1'b0;
		rsp_d       = '0;
		case (state_q)
			S_CLEAR: begin
				ram_ctl.en = 1'b1;
				ram_ctl.we = 1'b1;
				ram_addr   = cnt_q[AW-1:0];
				cnt_d      = clr_last ? '0 : cnt_q + LW'(1);
			end
			S_IDLE: begin
				cnt_d = '0;
				if (accept) begin
					if (req.cmd == CMD_ALLOC) begin
						if (req.page_frame != '0) begin
							emit            = 1'b1;
							rsp_d.status    = STAT_MAPPED;
							rsp_d.frame_out = req.page_frame;
						end
					end else if (req.page_frame == '0) begin
						emit         = 1'b1;
						rsp_d.status = STAT_NONE;
					end else if (in_range) begin
						ram_ctl.en = 1'b1;
						ram_addr   = in_word[AW-1:0];
					end else begin
						emit         = 1'b1;
						rsp_d.status = STAT_FREED;
					end
				end
			end
			S_SCAN: begin
				if (scan_issue) begin
					ram_ctl.en  = 1'b1;
					ram_addr    = cnt_q[AW-1:0];
					cnt_d       = cnt_q + LW'(1);
					chk_valid_d = 1'b1;
				end else if (!scan_found) begin
					emit         = 1'b1;
					rsp_d.status = STAT_FULL;
				end
			end
			S_ALLOC_WR: begin
				ram_ctl.en        = 1'b1;
				ram_ctl.we        = 1'b1;
				ram_addr          = chk_addr_q;
				ram_wdata         = ram_rdata | zero_onehot;
				emit              = 1'b1;
				rsp_d.status      = STAT_ALLOCATED;
				rsp_d.frame_out   = FRAME_W'({chk_addr_q, zero_idx});
				rsp_d.present_out = 1'b1;
				rsp_d.rw_out      = req_q.writable;
				rsp_d.user_out    = !req_q.kernel_mode;
			end
			S_FREE_WR: begin
				ram_ctl.en   = 1'b1;
				ram_ctl.we   = 1'b1;
				ram_addr     = q_word[AW-1:0];
				ram_wdata    = ram_rdata & ~free_mask;
				emit         = 1'b1;
				rsp_d.status = STAT_FREED;
			end
			default: begin
				cnt_d = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cnt_q         <= '0;
			chk_valid_q   <= 1'b0;
			done_q        <= 1'b0;
			frame_count_q <= FRAME_COUNT_RST;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			chk_valid_q <= chk_valid_d;
			done_q      <= emit;
			if (cfg_valid && cfg_ready) begin
				frame_count_q <= cfg_data;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_SCAN && scan_issue) begin
			chk_addr_q <= cnt_q[AW-1:0];
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// File: rtl/core/fba_checker.sv
// Port-level assertions for the frame bitmap allocator, bound to the top level.
// Depends on fba_pkg and frame_bitmap_allocator_unit_defines.svh.
`include "frame_bitmap_allocator_unit_defines.svh"

module fba_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input fba_pkg::fba_req_t req,
	input logic              done,
	input fba_pkg::fba_rsp_t rsp
);
	import fba_pkg::*;

	logic flags_any, no_frame_stat, scan_req;

	// shorthand terms
	assign flags_any     = rsp.present_out || rsp.rw_out || rsp.user_out;
	assign no_frame_stat = (rsp.status == STAT_FULL) || (rsp.status == STAT_NONE);
	assign scan_req      = start && !busy && req.cmd == CMD_ALLOC && req.page_frame == '0;

	// flags are only set on a fresh allocation
	`FBA_ASSERT_IMPL(a_flags_clear, done && rsp.status != STAT_ALLOCATED, !flags_any)

	// an allocation always marks the entry present
	`FBA_ASSERT_IMPL(a_alloc_present, done && rsp.status == STAT_ALLOCATED, rsp.present_out)

	// no frame handed back when full or nothing to free
	`FBA_ASSERT_IMPL(a_zero_frame, done && no_frame_stat, rsp.frame_out == '0)

	// an unmapped allocate request starts a scan
	`FBA_ASSERT_NEXT(a_scan_busy, scan_req, busy)

endmodule

bind frame_bitmap_allocator_unit fba_checker u_fba_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.req   (req),
	.done  (done),
	.rsp   (rsp)
);
